// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the glyph blend RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define GCPB_CHECK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checks that a condition in one cycle implies an expression in the next.
`define GCPB_CHECK_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ----- rtl/gcpb_pkg.sv -----
// Types and constants shared by the glyph coverage pixel blend modules.
package gcpb_pkg;

    localparam int COV_W      = 8;
    localparam int PIXEL_W    = 32;
    localparam int COLOR_W    = 24;
    localparam int SPREAD_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Largest spread the register can express.
    localparam int SPREAD_TAPS = (1 << SPREAD_W) - 1;

    localparam logic [PIXEL_W-1:0] ZERO_BASE_PIXEL = 32'h8080_8080;
    localparam logic [7:0]         CHANNEL_MAX     = 8'hFF;
    localparam logic [SPREAD_W-1:0] SPREAD_RESET   = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FG_COLOR  = 3'd0,
        CFG_BG_SAMPLE = 3'd1,
        CFG_FULL_BG   = 3'd2,
        CFG_EMBOLDEN  = 3'd3,
        CFG_SPREAD    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [COLOR_W-1:0]  fg_color;
        logic [PIXEL_W-1:0]  bg_sample;
        logic                full_bg;
        logic                embolden;
        logic [SPREAD_W-1:0] spread;
    } cfg_t;

endpackage

// ----- rtl/gcpb_window.sv -----
// Coverage history window of one glyph row and the embolden maximum over it.
`include "assert_macros.svh"

module gcpb_window #(
    parameter int MAX_SPREAD = 15
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     advance,
    input  logic [gcpb_pkg::COV_W-1:0] coverage,
    input  logic                     row_start,
    input  gcpb_pkg::cfg_t           cfg,
    output logic [gcpb_pkg::COV_W-1:0] eff_coverage
);
    import gcpb_pkg::*;

    localparam int NTAP   = (MAX_SPREAD < SPREAD_TAPS) ? MAX_SPREAD : SPREAD_TAPS;
    localparam int LEAVES = SPREAD_TAPS + 1;

    logic [COV_W-1:0] window_reg [MAX_SPREAD];
    logic [COV_W-1:0] tap        [SPREAD_TAPS];
    logic [COV_W-1:0] node       [1:2*LEAVES-1];

    for (genvar k = 0; k < SPREAD_TAPS; k++) begin : g_tap
        if (k < NTAP) begin : g_used
            assign tap[k] = window_reg[k];
        end else begin : g_unused
            assign tap[k] = '0;
        end
    end

    // Binary max tree: leaf 0 is the current byte, the others are masked taps.
    always_comb begin
        node[LEAVES] = coverage;
        for (int k = 1; k < LEAVES; k++) begin
            node[LEAVES+k] = (cfg.embolden && !row_start &&
                              (SPREAD_W'(k - 1) < cfg.spread)) ? tap[k-1] : '0;
        end
        for (int k = LEAVES - 1; k >= 1; k--) begin
            node[k] = (node[2*k] > node[2*k+1]) ? node[2*k] : node[2*k+1];
        end
    end

    assign eff_coverage = node[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_SPREAD; i++) begin
                window_reg[i] <= '0;
            end
        end else if (advance) begin
            for (int i = 1; i < MAX_SPREAD; i++) begin
                window_reg[i] <= row_start ? '0 : window_reg[i-1];
            end
            window_reg[0] <= coverage;
        end
    end

    `GCPB_CHECK_NEXT(a_window_newest, advance, window_reg[0] == $past(coverage),
        "newest window entry does not hold the last coverage byte")
    `GCPB_CHECK(a_eff_not_below_cov, !advance || (eff_coverage >= coverage),
        "effective coverage is below the current coverage byte")

endmodule

// ----- rtl/gcpb_blend.sv -----
// Blends the foreground color into the base pixel by the effective coverage.
module gcpb_blend (
    input  logic [gcpb_pkg::COV_W-1:0]   eff_coverage,
    input  logic [gcpb_pkg::PIXEL_W-1:0] dest_pixel,
    input  gcpb_pkg::cfg_t               cfg,
    output logic                         write_pixel,
    output logic [gcpb_pkg::PIXEL_W-1:0] pixel_out
);
    import gcpb_pkg::*;

    // Moves one channel toward the foreground by diff * cov / 256, rounded toward zero.
    function automatic logic [7:0] blend_chan(input logic [7:0] base,
                                              input logic [7:0] fg,
                                              input logic [7:0] cov);
        logic signed [9:0]  diff;
        logic signed [18:0] prod;
        logic signed [18:0] q;
        diff = $signed({2'b00, fg}) - $signed({2'b00, base});
        prod = 19'(diff) * 19'($signed({1'b0, cov}));
        if (prod < 0) begin
            q = (prod + 19'sd255) >>> 8;
        end else begin
            q = prod >>> 8;
        end
        return base + q[7:0];
    endfunction

    logic [PIXEL_W-1:0] base_sel;
    logic [PIXEL_W-1:0] base;
    logic [8:0]         alpha_sum;
    logic [7:0]         alpha;

    always_comb begin
        base_sel  = cfg.full_bg ? dest_pixel : cfg.bg_sample;
        base      = (base_sel == '0) ? ZERO_BASE_PIXEL : base_sel;
        alpha_sum = {1'b0, base[31:24]} + {1'b0, eff_coverage};
        alpha     = alpha_sum[8] ? CHANNEL_MAX : alpha_sum[7:0];
        write_pixel = (eff_coverage != '0);
        if (write_pixel) begin
            pixel_out = {alpha,
                         blend_chan(base[23:16], cfg.fg_color[23:16], eff_coverage),
                         blend_chan(base[15:8],  cfg.fg_color[15:8],  eff_coverage),
                         blend_chan(base[7:0],   cfg.fg_color[7:0],   eff_coverage)};
        end else begin
            pixel_out = '0;
        end
    end

endmodule

// ----- rtl/glyph_coverage_pixel_blend.sv -----
// Top level of the antialiased glyph coverage to ARGB8888 pixel blend.
//
// Each input word carries one glyph coverage byte, the destination pixel and a
// row start flag; each result word carries a write flag and the blended pixel.
// Both channels use valid and ready. The configuration port is a plain write
// port (cfg_wen, cfg_index, cfg_wdata); the user must write it only while the
// block is idle, which it does not enforce. An accepted word is registered in
// the input register, its result in the result register on advance, raising
// m_valid. The window maximum and the three channel multipliers sit between the
// input register and the result register, which sustains one word per cycle
// unless stalled. When the receiver stalls, the result register holds and the
// input register still takes one more word; s_ready then drops until the result
// drains. Reset clears both stages, the coverage window and all configuration
// registers (spread returns to one). The window keeps the last MAX_SPREAD
// coverage bytes of the current row; row_start forgets them before use.
`include "assert_macros.svh"

module glyph_coverage_pixel_blend #(
    parameter int MAX_SPREAD = 15
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wen,
    input  logic [gcpb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gcpb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [gcpb_pkg::COV_W-1:0]      s_coverage,
    input  logic [gcpb_pkg::PIXEL_W-1:0]    s_dest_pixel,
    input  logic                            s_row_start,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_write_pixel,
    output logic [gcpb_pkg::PIXEL_W-1:0]    m_pixel_out
);
    import gcpb_pkg::*;

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    logic [COV_W-1:0]   cov_reg;
    logic [PIXEL_W-1:0] dest_reg;
    logic               row_start_reg;
    logic               out_valid_reg;
    logic               write_reg;
    logic [PIXEL_W-1:0] pixel_reg;

    logic               advance;
    logic [COV_W-1:0]   eff_coverage;
    logic               write_next;
    logic [PIXEL_W-1:0] pixel_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fg_color  <= '0;
            cfg_reg.bg_sample <= '0;
            cfg_reg.full_bg   <= 1'b0;
            cfg_reg.embolden  <= 1'b0;
            cfg_reg.spread    <= SPREAD_RESET;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                CFG_FG_COLOR:  cfg_reg.fg_color  <= cfg_wdata[COLOR_W-1:0];
                CFG_BG_SAMPLE: cfg_reg.bg_sample <= cfg_wdata[PIXEL_W-1:0];
                CFG_FULL_BG:   cfg_reg.full_bg   <= cfg_wdata[0];
                CFG_EMBOLDEN:  cfg_reg.embolden  <= cfg_wdata[0];
                CFG_SPREAD:    cfg_reg.spread    <= cfg_wdata[SPREAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cov_reg       <= s_coverage;
            dest_reg      <= s_dest_pixel;
            row_start_reg <= s_row_start;
        end
    end

    gcpb_window #(
        .MAX_SPREAD(MAX_SPREAD)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .coverage    (cov_reg),
        .row_start   (row_start_reg),
        .cfg         (cfg_reg),
        .eff_coverage(eff_coverage)
    );

    gcpb_blend u_blend (
        .eff_coverage(eff_coverage),
        .dest_pixel  (dest_reg),
        .cfg         (cfg_reg),
        .write_pixel (write_next),
        .pixel_out   (pixel_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            write_reg <= write_next;
            pixel_reg <= pixel_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_write_pixel = write_reg;
    assign m_pixel_out   = pixel_reg;

    `GCPB_CHECK(a_no_write_zero_pixel, !(m_valid && !m_write_pixel) || (m_pixel_out == '0),
        "skipped pixel carries a nonzero value")
    `GCPB_CHECK(a_write_alpha_nonzero, !(m_valid && m_write_pixel) || (m_pixel_out[31:24] != '0),
        "written pixel has zero alpha")
    `GCPB_CHECK_NEXT(a_held_word_kept, in_valid_reg && !advance, in_valid_reg,
        "stalled input word was dropped")

endmodule
